### sv/targa_rle_decoder_defines.svh
// Assertion macros for the TGA RLE decoder.
`ifndef TARGA_RLE_DECODER_DEFINES_SVH
`define TARGA_RLE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define TRLE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define TRLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define TRLE_ASSERT_SAME(label, clk, rst, ante, cons)

`define TRLE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### sv/trle_pkg.sv
package trle_pkg;

   localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
   localparam logic [7:0] HDR_RUN_BIT    = 8'h80;

   localparam logic [1:0] CSR_CHANNEL_COUNT   = 2'd0;
   localparam logic [1:0] CSR_PIXELS_PER_LINE = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_OVERRUN = 2'd1,
      STATUS_TRUNC   = 2'd2
   } status_type;

   typedef struct packed {
      logic        in_pkt;
      logic        run_mode;
      logic [7:0]  packet_left;
      logic [1:0]  byte_index;
      logic [23:0] pixel_bytes;
      logic [15:0] pixels_left;
   } parse_state_type;

   typedef struct packed {
      logic [3:0][7:0] chan;
      logic [7:0]      repeat_res;
      logic            line_done;
      status_type      status;
   } result_type;

   function automatic logic [2:0] eff_channels(input logic [2:0] c);
      logic [2:0] r;
      if (c == 3'd0) begin
         r = 3'd1;
      end else if (c > 3'd4) begin
         r = 3'd4;
      end else begin
         r = c;
      end
      return r;
   endfunction

   function automatic logic [15:0] eff_line(input logic [15:0] p);
      return (p == 16'd0) ? 16'd1 : p;
   endfunction

endpackage

### sv/trle_step.sv
module trle_step
   import trle_pkg::*;
(
   input  parse_state_type cur,
   input  logic [2:0]      channels,
   input  logic [15:0]     line_len,
   input  logic [7:0]      data_byte,
   input  logic            stream_end,
   output parse_state_type nxt,
   output result_type      res,
   output logic            have
);

   logic complete;

   assign complete = ({1'b0, cur.byte_index} + 3'd1) >= channels;

   always_comb begin
      nxt  = cur;
      res  = '0;
      have = 1'b0;
      if (!cur.in_pkt) begin
         if (cur.pixels_left == 16'd0) begin
            nxt.pixels_left = line_len;
         end
         nxt.packet_left = (data_byte & HDR_COUNT_MASK) + 8'd1;
         nxt.run_mode    = (data_byte & HDR_RUN_BIT) != 8'd0;
         nxt.in_pkt      = 1'b1;
         nxt.byte_index  = 2'd0;
         nxt.pixel_bytes = '0;
      end else if (complete) begin
         res.chan[0] = cur.pixel_bytes[7:0];
         res.chan[1] = cur.pixel_bytes[15:8];
         res.chan[2] = cur.pixel_bytes[23:16];
         res.chan[3] = 8'd0;
         res.chan[cur.byte_index] = data_byte;
         for (int k = 0; k < 4; k++) begin
            if (3'(k) >= channels) begin
               res.chan[k] = 8'd0;
            end
         end
         if (cur.run_mode) begin
            if ({8'd0, cur.packet_left} > cur.pixels_left) begin
               res.repeat_res = cur.pixels_left[7:0];
               res.status     = STATUS_OVERRUN;
            end else begin
               res.repeat_res = cur.packet_left;
            end
            nxt.pixels_left = cur.pixels_left - {8'd0, res.repeat_res};
            nxt.packet_left = 8'd0;
            nxt.in_pkt      = 1'b0;
         end else begin
            if (cur.pixels_left == 16'd0) begin
               res.status = STATUS_OVERRUN;
            end else begin
               res.repeat_res  = 8'd1;
               nxt.pixels_left = cur.pixels_left - 16'd1;
            end
            if (cur.packet_left != 8'd0) begin
               nxt.packet_left = cur.packet_left - 8'd1;
            end
            if (nxt.packet_left == 8'd0) begin
               nxt.in_pkt = 1'b0;
            end
         end
         res.line_done   = (res.repeat_res != 8'd0) && (nxt.pixels_left == 16'd0);
         nxt.byte_index  = 2'd0;
         nxt.pixel_bytes = '0;
         have            = 1'b1;
      end else begin
         case (cur.byte_index)
            2'd0:    nxt.pixel_bytes[7:0]   = cur.pixel_bytes[7:0] | data_byte;
            2'd1:    nxt.pixel_bytes[15:8]  = cur.pixel_bytes[15:8] | data_byte;
            2'd2:    nxt.pixel_bytes[23:16] = cur.pixel_bytes[23:16] | data_byte;
            default: nxt.pixel_bytes        = cur.pixel_bytes;
         endcase
         nxt.byte_index = cur.byte_index + 2'd1;
      end

      if (stream_end) begin
         if (nxt.pixels_left != 16'd0) begin
            have       = 1'b1;
            res.status = STATUS_TRUNC;
         end
         nxt.in_pkt      = 1'b0;
         nxt.run_mode    = 1'b0;
         nxt.packet_left = 8'd0;
         nxt.byte_index  = 2'd0;
         nxt.pixel_bytes = '0;
         nxt.pixels_left = line_len;
      end
   end

endmodule

### sv/targa_rle_decoder.sv
// Channel  Dir  Handshake          Payload
// req      in   req_valid/stall    data_byte, stream_end (one compressed byte)
// rsp      out  rsp_valid/stall    chan0..chan3, repeat_res, line_done, status
// csr      in   csr_valid/ready    csr_index (register), csr_data (value)
//
// One byte per cycle while req_stall is low; a result appears in the cycle after its byte.
// The parser decodes each byte combinationally; results go into a single result register.
// req_stall is high only while the result register is full and rsp is stalled.
// Synchronous active-high reset: channel_count 4, pixels_per_line 1, parser idle.
// csr_ready is always high; writes are expected only while the decoder is idle.
`include "targa_rle_decoder_defines.svh"

module targa_rle_decoder
   import trle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_chan0,
   output logic [7:0]  rsp_chan1,
   output logic [7:0]  rsp_chan2,
   output logic [7:0]  rsp_chan3,
   output logic [7:0]  rsp_repeat_res,
   output logic        rsp_line_done,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [2:0]      channel_count_ff;
   logic [15:0]     pixels_per_line_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_state;
   result_type      res_ff;
   result_type      res_in;
   logic            rsp_valid_ff;
   logic            have;
   logic            req_take;
   logic            csr_take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   trle_step u_step (
      .cur        (state_ff),
      .channels   (eff_channels(channel_count_ff)),
      .line_len   (eff_line(pixels_per_line_ff)),
      .data_byte  (req_data_byte),
      .stream_end (req_stream_end),
      .nxt        (step_state),
      .res        (res_in),
      .have       (have)
   );

   always_comb begin
      state_in = state_ff;
      if (req_take) begin
         state_in = step_state;
      end
      if (csr_take && (csr_index == CSR_PIXELS_PER_LINE)) begin
         state_in.pixels_left = eff_line(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff   <= 3'd4;
         pixels_per_line_ff <= 16'd1;
         state_ff           <= '{in_pkt: 1'b0, run_mode: 1'b0, packet_left: 8'd0,
                                 byte_index: 2'd0, pixel_bytes: 24'd0,
                                 pixels_left: 16'd1};
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_take) begin
            case (csr_index)
               CSR_CHANNEL_COUNT:   channel_count_ff   <= csr_data[2:0];
               CSR_PIXELS_PER_LINE: pixels_per_line_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_take) begin
            rsp_valid_ff <= have;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && have) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chan0      = res_ff.chan[0];
   assign rsp_chan1      = res_ff.chan[1];
   assign rsp_chan2      = res_ff.chan[2];
   assign rsp_chan3      = res_ff.chan[3];
   assign rsp_repeat_res = res_ff.repeat_res;
   assign rsp_line_done  = res_ff.line_done;
   assign rsp_status     = res_ff.status;

   `TRLE_ASSERT_SAME(a_done_has_pixels, clock, reset, rsp_valid_ff && res_ff.line_done, res_ff.repeat_res != 8'd0)
   `TRLE_ASSERT_SAME(a_trunc_not_done, clock, reset, rsp_valid_ff && res_ff.status == STATUS_TRUNC, !res_ff.line_done)
   `TRLE_ASSERT_SAME(a_packet_nonempty, clock, reset, state_ff.in_pkt, state_ff.packet_left != 8'd0)
   `TRLE_ASSERT_NEXT(a_end_resets_parser, clock, reset, req_take && req_stream_end, !state_ff.in_pkt)

endmodule
